### src/wpsm_pkg.sv
// Package for the wildcard path suffix matcher.
// Holds the command codes and the queue entry type shared by the front end, the queue and the core.
// No dependencies.
package wpsm_pkg;

  localparam int SYMBOL_W = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TEXT   = 2'd2;

  localparam logic [1:0] KIND_ORDINARY = 2'd0;
  localparam logic [1:0] KIND_SINGLE   = 2'd1;
  localparam logic [1:0] KIND_STAR     = 2'd2;

  typedef enum logic [2:0] {
    CMD_CLEAR,
    CMD_ORDINARY,
    CMD_SINGLE,
    CMD_STAR,
    CMD_TEXT,
    CMD_TEXT_LAST
  } cmd_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [SYMBOL_W-1:0] symbol;
  } entry_t;

endpackage

### src/wpsm_front.sv
// Front end of the wildcard path suffix matcher: decodes each input request into a command.
// Requests with no effect are dropped here. Depends on wpsm_pkg.
module wpsm_front (
  input  logic [1:0]                  op,
  input  logic [1:0]                  term_kind,
  input  logic                        is_last,
  input  logic [wpsm_pkg::SYMBOL_W-1:0] symbol,
  output logic                        keep,
  output wpsm_pkg::entry_t            entry
);

  always_comb begin
    keep = 1'b0;
    entry.cmd = wpsm_pkg::CMD_CLEAR;
    entry.symbol = symbol;
    unique case (op)
      wpsm_pkg::OP_CLEAR: begin
        keep = 1'b1;
      end
      wpsm_pkg::OP_APPEND: begin
        unique case (term_kind)
          wpsm_pkg::KIND_ORDINARY: begin
            keep = 1'b1;
            entry.cmd = wpsm_pkg::CMD_ORDINARY;
          end
          wpsm_pkg::KIND_SINGLE: begin
            keep = 1'b1;
            entry.cmd = wpsm_pkg::CMD_SINGLE;
          end
          wpsm_pkg::KIND_STAR: begin
            keep = 1'b1;
            entry.cmd = wpsm_pkg::CMD_STAR;
          end
          default: keep = 1'b0;
        endcase
      end
      wpsm_pkg::OP_TEXT: begin
        keep = 1'b1;
        entry.cmd = is_last ? wpsm_pkg::CMD_TEXT_LAST : wpsm_pkg::CMD_TEXT;
      end
      default: keep = 1'b0;
    endcase
  end

endmodule

### src/wpsm_queue.sv
// Short command queue between the front end and the matcher core.
// Depends on wpsm_pkg for the entry type and depth.
module wpsm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wpsm_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output wpsm_pkg::entry_t head_entry
);

  localparam int PtrW = $clog2(wpsm_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(wpsm_pkg::QUEUE_DEPTH + 1);

  wpsm_pkg::entry_t slots [wpsm_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full = (count == CntW'(wpsm_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PtrW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= PtrW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/wpsm_core.sv
// Matcher core: holds the pattern and the partial match vector and executes queued commands.
// Owns the output register. Depends on wpsm_pkg.
module wpsm_core #(
  parameter int MAX_TERMS = 32,
  parameter int SYMBOL_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  wpsm_pkg::entry_t head_entry,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_matched,
  output logic             out_truncated
);

  localparam int SymW = (SYMBOL_BITS < wpsm_pkg::SYMBOL_W) ? SYMBOL_BITS : wpsm_pkg::SYMBOL_W;
  localparam int CntW = $clog2(MAX_TERMS + 1);
  localparam int IdxW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  logic [SymW-1:0]      pattern_symbols [MAX_TERMS];
  logic [MAX_TERMS-1:0] single_wild_mask;
  logic [MAX_TERMS-1:0] before_star_mask;
  logic [CntW-1:0]      pattern_count;
  logic                 has_star;
  logic [MAX_TERMS-1:0] partial_vector;
  logic                 overflow_flag;

  logic [SymW-1:0]      sym;
  logic [MAX_TERMS-1:0] match_vec;
  logic [MAX_TERMS-1:0] used_mask;
  logic [MAX_TERMS-1:0] r_next;
  logic [CntW-1:0]      count_m1;
  logic [IdxW-1:0]      last_idx;
  logic [IdxW-1:0]      wr_idx;
  logic                 full_pattern;
  logic                 matched_next;
  logic                 gives_result;

  assign sym = head_entry.symbol[SymW-1:0];
  assign count_m1 = pattern_count - CntW'(1);
  assign last_idx = count_m1[IdxW-1:0];
  assign wr_idx = pattern_count[IdxW-1:0];
  assign full_pattern = (pattern_count == CntW'(MAX_TERMS));

  always_comb begin
    for (int k = 0; k < MAX_TERMS; k++) begin
      match_vec[k] = single_wild_mask[k] || (pattern_symbols[k] == sym);
      used_mask[k] = (CntW'(k) < pattern_count);
    end
    r_next = ((((partial_vector << 1) | MAX_TERMS'(1)) & match_vec)
             | (partial_vector & before_star_mask)) & used_mask;
    matched_next = (pattern_count == '0) ? has_star : r_next[last_idx];
  end

  assign gives_result = (head_entry.cmd == wpsm_pkg::CMD_TEXT_LAST);
  assign pop = head_valid && (!gives_result || !out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (pop && !full_pattern
        && (head_entry.cmd == wpsm_pkg::CMD_ORDINARY
            || head_entry.cmd == wpsm_pkg::CMD_SINGLE)) begin
      pattern_symbols[wr_idx] <= sym;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && gives_result) begin
      out_matched <= matched_next;
      out_truncated <= overflow_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      single_wild_mask <= '0;
      before_star_mask <= '0;
      pattern_count <= '0;
      has_star <= 1'b0;
      partial_vector <= '0;
      overflow_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && gives_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        case (head_entry.cmd) inside
          wpsm_pkg::CMD_CLEAR: begin
            single_wild_mask <= '0;
            before_star_mask <= '0;
            pattern_count <= '0;
            has_star <= 1'b0;
            partial_vector <= '0;
            overflow_flag <= 1'b0;
          end
          wpsm_pkg::CMD_ORDINARY, wpsm_pkg::CMD_SINGLE: begin
            if (full_pattern) begin
              overflow_flag <= 1'b1;
            end else begin
              if (head_entry.cmd == wpsm_pkg::CMD_SINGLE) begin
                single_wild_mask[wr_idx] <= 1'b1;
              end
              pattern_count <= pattern_count + 1'b1;
            end
          end
          wpsm_pkg::CMD_STAR: begin
            has_star <= 1'b1;
            if (pattern_count != '0) begin
              before_star_mask[last_idx] <= 1'b1;
            end
          end
          wpsm_pkg::CMD_TEXT: begin
            partial_vector <= r_next;
          end
          wpsm_pkg::CMD_TEXT_LAST: begin
            partial_vector <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

### src/wildcard_path_suffix_matcher.sv
// Top level of the wildcard path suffix matcher.
// Instantiates wpsm_front, wpsm_queue and wpsm_core; depends on wpsm_pkg.
//
// Usage: every request on the s_ channel is one command. op 0 clears the pattern, op 1
// appends a term (ordinary symbol, single wildcard or unlimited wildcard, chosen by
// term_kind), op 2 streams one text symbol. A text symbol with tlast high closes the
// path and yields one request on the m_ channel carrying matched and truncated.
// Other requests yield nothing on the m_ channel.
// Throughput: one request per cycle while s_tready is high. Every command finishes in
// a single pass of the core, which updates all pattern positions in parallel.
// Result path: the closing text symbol is written into the queue, then executed from
// the queue head into the output register, which raises m_tvalid.
// When the receiver stalls, the core holds the result and keeps executing commands
// that produce none; a second result waits in the two-entry queue, and s_tready falls
// only when that queue is full. Reset clears the pattern, the match state, the queue
// and m_tvalid; the block accepts requests in the cycle after reset.
module wildcard_path_suffix_matcher #(
  parameter int MAX_TERMS = 32,
  parameter int SYMBOL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [15:0] symbol
  input  logic [3:0]  s_tuser,  // [1:0] op, [3:2] term_kind
  input  logic        s_tlast,  // is_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata   // [0] matched, [1] truncated, [7:2] zero
);

  logic             keep;
  logic             full;
  logic             push;
  logic             pop;
  logic             head_valid;
  wpsm_pkg::entry_t front_entry;
  wpsm_pkg::entry_t head_entry;
  logic             matched;
  logic             truncated;

  assign s_tready = !rst && !full;
  assign push = s_tvalid && s_tready && keep;
  assign m_tdata = {6'b0, truncated, matched};

  wpsm_front u_front (
    .op        (s_tuser[1:0]),
    .term_kind (s_tuser[3:2]),
    .is_last   (s_tlast),
    .symbol    (s_tdata),
    .keep      (keep),
    .entry     (front_entry)
  );

  wpsm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (front_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  wpsm_core #(
    .MAX_TERMS   (MAX_TERMS),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_entry    (head_entry),
    .pop           (pop),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_matched   (matched),
    .out_truncated (truncated)
  );

endmodule

### sim/wildcard_path_suffix_matcher_test.sv
// Self-checking testbench for wildcard_path_suffix_matcher: it runs directed and random
// pattern loads and text paths, and predicts each match verdict in parallel.
// Depends on wpsm_pkg and the matcher RTL only.
`timescale 1ns / 100ps

module wildcard_path_suffix_matcher_test;

  localparam logic [1:0] OP_NOISE = 2'd3;
  localparam logic [1:0] KIND_BAD = 2'd3;
  localparam int PAT_CAP = 32;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] symbol;
    logic [1:0]  kind;
    logic        last;
  } path_req_t;

  typedef struct packed {
    logic matched;
    logic truncated;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [15:0] symbol
  logic [3:0]  s_tuser = '0;   // [1:0] op, [3:2] term_kind
  logic        s_tlast = 1'b0; // is_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [0] matched, [1] truncated, [7:2] zero

  path_req_t path_req_q[$];
  verdict_t  verdict_q[$];
  path_req_t next_req;
  int        real_items = 0;
  int        offered_reqs = 0;
  int        accepted_reqs = 0;
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        hold_cycles = 0;
  bit        backlog_done = 1'b0;

  logic [15:0] pat_sym[0:PAT_CAP-1];
  logic [31:0] wild_single = '0;
  logic [31:0] star_hold = '0;
  int          term_count = 0;
  logic        star_seen = 1'b0;
  logic [31:0] match_state = '0;
  logic        dropped = 1'b0;

  wildcard_path_suffix_matcher dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  task automatic queue_req(input logic [1:0] op, input logic [15:0] sym,
                           input logic [1:0] kind, input logic last);
    path_req_q.push_back('{op: op, symbol: sym, kind: kind, last: last});
    if (op != OP_NOISE) real_items++;
  endtask

  function automatic logic [15:0] pick_symbol(input logic [15:0] base);
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 65535));
    return base ^ 16'($urandom_range(0, 3));
  endfunction

  task automatic advance_matcher(input logic [1:0] op, input logic [15:0] sym,
                                 input logic [1:0] kind, input logic last);
    logic [31:0] vec;
    logic [31:0] used;
    logic [31:0] upd;
    verdict_t    v;
    case (op)
      wpsm_pkg::OP_CLEAR: begin
        wild_single = '0;
        star_hold = '0;
        term_count = 0;
        star_seen = 1'b0;
        match_state = '0;
        dropped = 1'b0;
      end
      wpsm_pkg::OP_APPEND: begin
        if (kind == wpsm_pkg::KIND_STAR) begin
          star_seen = 1'b1;
          if (term_count > 0) star_hold[term_count-1] = 1'b1;
        end else if (kind == wpsm_pkg::KIND_ORDINARY || kind == wpsm_pkg::KIND_SINGLE) begin
          if (term_count >= PAT_CAP) begin
            dropped = 1'b1;
          end else begin
            pat_sym[term_count] = sym;
            if (kind == wpsm_pkg::KIND_SINGLE) wild_single[term_count] = 1'b1;
            term_count++;
          end
        end
      end
      wpsm_pkg::OP_TEXT: begin
        vec = wild_single;
        for (int k = 0; k < term_count; k++) begin
          if (!wild_single[k] && pat_sym[k] == sym) vec[k] = 1'b1;
        end
        used = (term_count >= PAT_CAP) ? '1 : 32'((64'd1 << term_count) - 64'd1);
        upd = ((((match_state << 1) | 32'd1) & vec) | (match_state & star_hold)) & used;
        match_state = upd;
        if (last) begin
          v.matched = (term_count == 0) ? star_seen : upd[term_count-1];
          v.truncated = dropped;
          verdict_q.push_back(v);
          match_state = '0;
        end
      end
      default: begin
      end
    endcase
  endtask

  // Request driver.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && offered_reqs != accepted_reqs) begin
    end else if (path_req_q.size() != 0 &&
                 ((accepted_reqs >= 1000 && accepted_reqs < 1300) ||
                  $urandom_range(0, 99) >= 7)) begin
      next_req = path_req_q.pop_front();
      s_tdata <= next_req.symbol;
      s_tuser <= {next_req.kind, next_req.op};
      s_tlast <= next_req.last;
      s_tvalid <= 1'b1;
      offered_reqs++;
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Result receiver, with one long hold-off to back the block up.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!backlog_done && accepted_reqs >= 500) begin
        hold_cycles = 150;
        backlog_done = 1'b1;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (accepted_reqs >= 1000 && accepted_reqs < 1300) ||
                    $urandom_range(0, 99) >= 7;
      end
    end
  end

  // Monitor: the result is checked before this edge's request is predicted.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got tdata %h", $time, m_tdata);
          mismatch_count++;
        end else begin
          if (m_tdata[0] !== verdict_q[0].matched) begin
            $display("%0t: matched expected %0b, got %0b", $time,
                     verdict_q[0].matched, m_tdata[0]);
            mismatch_count++;
          end
          if (m_tdata[1] !== verdict_q[0].truncated) begin
            $display("%0t: truncated expected %0b, got %0b", $time,
                     verdict_q[0].truncated, m_tdata[1]);
            mismatch_count++;
          end
          void'(verdict_q.pop_front());
        end
      end
      if (s_tvalid && s_tready) begin
        advance_matcher(s_tuser[1:0], s_tdata, s_tuser[3:2], s_tlast);
        accepted_reqs++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    logic [1:0]  gkind[0:39];
    logic [15:0] gsym[0:39];
    logic [15:0] path_sym[0:127];
    logic [15:0] base;
    int          glen;
    int          plen;
    int          roll;
    int          n_paths;

    // Directed part: empty pattern, all-star pattern, star holding, ignored codes,
    // and a leading star.
    queue_req(wpsm_pkg::OP_TEXT, 16'h1234, wpsm_pkg::KIND_ORDINARY, 1'b1);
    queue_req(wpsm_pkg::OP_APPEND, 16'hFFFF, wpsm_pkg::KIND_STAR, 1'b0);
    queue_req(wpsm_pkg::OP_TEXT, 16'h0000, KIND_BAD, 1'b1);
    queue_req(wpsm_pkg::OP_CLEAR, 16'hFFFF, KIND_BAD, 1'b1);
    queue_req(wpsm_pkg::OP_APPEND, 16'hFFFF, wpsm_pkg::KIND_ORDINARY, 1'b0);
    queue_req(wpsm_pkg::OP_APPEND, 16'h0000, wpsm_pkg::KIND_SINGLE, 1'b1);
    queue_req(wpsm_pkg::OP_APPEND, 16'h0000, wpsm_pkg::KIND_STAR, 1'b0);
    queue_req(wpsm_pkg::OP_APPEND, 16'h0000, wpsm_pkg::KIND_ORDINARY, 1'b0);
    queue_req(wpsm_pkg::OP_APPEND, 16'hAAAA, KIND_BAD, 1'b0);
    queue_req(wpsm_pkg::OP_TEXT, 16'h0000, wpsm_pkg::KIND_ORDINARY, 1'b0);
    queue_req(wpsm_pkg::OP_TEXT, 16'hFFFF, wpsm_pkg::KIND_ORDINARY, 1'b0);
    queue_req(wpsm_pkg::OP_TEXT, 16'h5A5A, wpsm_pkg::KIND_ORDINARY, 1'b0);
    queue_req(wpsm_pkg::OP_TEXT, 16'h1111, wpsm_pkg::KIND_ORDINARY, 1'b0);
    queue_req(wpsm_pkg::OP_TEXT, 16'h2222, wpsm_pkg::KIND_ORDINARY, 1'b0);
    queue_req(wpsm_pkg::OP_TEXT, 16'h0000, wpsm_pkg::KIND_ORDINARY, 1'b1);
    queue_req(OP_NOISE, 16'hFFFF, KIND_BAD, 1'b1);
    queue_req(wpsm_pkg::OP_TEXT, 16'hFFFF, wpsm_pkg::KIND_ORDINARY, 1'b1);
    queue_req(wpsm_pkg::OP_CLEAR, 16'h0000, wpsm_pkg::KIND_ORDINARY, 1'b0);
    queue_req(wpsm_pkg::OP_APPEND, 16'h0000, wpsm_pkg::KIND_STAR, 1'b0);
    queue_req(wpsm_pkg::OP_APPEND, 16'h8001, wpsm_pkg::KIND_ORDINARY, 1'b0);
    queue_req(wpsm_pkg::OP_TEXT, 16'h8001, wpsm_pkg::KIND_ORDINARY, 1'b1);

    // Random part: pattern loads followed by paths that mostly embed the pattern.
    while (real_items < 1750) begin
      base = 16'($urandom_range(0, 65535));
      glen = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 6);
      if ($urandom_range(0, 9) != 0)
        queue_req(wpsm_pkg::OP_CLEAR, 16'($urandom_range(0, 65535)),
                  2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      for (int i = 0; i < glen; i++) begin
        roll = $urandom_range(0, 99);
        gkind[i] = (roll < 60) ? wpsm_pkg::KIND_ORDINARY :
                   (roll < 80) ? wpsm_pkg::KIND_SINGLE :
                   (roll < 95) ? wpsm_pkg::KIND_STAR : KIND_BAD;
        gsym[i] = pick_symbol(base);
        queue_req(wpsm_pkg::OP_APPEND, gsym[i], gkind[i], 1'($urandom_range(0, 1)));
      end
      n_paths = $urandom_range(1, 4);
      for (int p = 0; p < n_paths; p++) begin
        plen = 0;
        if ($urandom_range(0, 9) == 0)
          queue_req(OP_NOISE, 16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)),
                    1'($urandom_range(0, 1)));
        roll = $urandom_range(0, 3);
        for (int j = 0; j < roll; j++) begin
          path_sym[plen] = pick_symbol(base);
          plen++;
        end
        if ($urandom_range(0, 3) != 0) begin
          for (int i = 0; i < glen; i++) begin
            if (gkind[i] == wpsm_pkg::KIND_ORDINARY) begin
              path_sym[plen] = gsym[i];
              plen++;
            end else if (gkind[i] == wpsm_pkg::KIND_SINGLE) begin
              path_sym[plen] = pick_symbol(base);
              plen++;
            end else if (gkind[i] == wpsm_pkg::KIND_STAR) begin
              roll = $urandom_range(0, 2);
              for (int j = 0; j < roll; j++) begin
                path_sym[plen] = pick_symbol(base);
                plen++;
              end
            end
          end
        end
        if ($urandom_range(0, 9) < 3) begin
          roll = $urandom_range(1, 2);
          for (int j = 0; j < roll; j++) begin
            path_sym[plen] = pick_symbol(base);
            plen++;
          end
        end
        if (plen == 0) begin
          path_sym[plen] = pick_symbol(base);
          plen++;
        end
        for (int j = 0; j < plen; j++)
          queue_req(wpsm_pkg::OP_TEXT, path_sym[j], 2'($urandom_range(0, 3)),
                    j == plen - 1);
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (path_req_q.size() != 0 || offered_reqs != accepted_reqs) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
